>>> src/bvp_pkg.sv
// Package for the battery voltage to percent unit: widths, chemistry codes,
// the linear-mode constants and the breakpoint tables with their lookup functions.
// No dependencies.
`timescale 1ns / 1ps

package bvp_pkg;

    // Field widths.
    localparam int MV_W    = 13;
    localparam int PCT_W   = 7;
    localparam int CHEM_W  = 2;

    // Table geometry: storage holds up to MAX_POINTS, a table uses at most TABLE_POINTS.
    localparam int MAX_POINTS   = 16;
    localparam int TABLE_POINTS = 8;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);

    // Divider geometry: the dividend is at most a percent drop times a voltage distance.
    localparam int NUM_W     = PCT_W + MV_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Chemistry codes.
    localparam logic [CHEM_W-1:0] CHEM_LIION = 2'd0;
    localparam logic [CHEM_W-1:0] CHEM_ALK   = 2'd1;
    localparam logic [CHEM_W-1:0] CHEM_COIN  = 2'd2;

    // Lithium-ion linear law: pct = mv * 2 / 15 - 459 between the clamps.
    // The divide by 15 is a reciprocal multiply: mv * 2 / 15 == (mv * 17478) >> 17,
    // exact for every voltage below the full clamp.
    localparam logic [MV_W-1:0]  LI_FULL_MV  = 13'd4200;
    localparam logic [MV_W-1:0]  LI_EMPTY_MV = 13'd3450;
    localparam int               LI_RECIP_W  = 15;
    localparam logic [LI_RECIP_W-1:0] LI_RECIP = 15'd17478;
    localparam int               LI_PROD_W   = MV_W + LI_RECIP_W;
    localparam int               LI_SHIFT    = 17;
    localparam logic [NUM_W-1:0] LI_OFFSET   = 20'd459;
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY   = 7'd0;

    // Point counts of the two tables.
    localparam int ALK_COUNT  = 8;
    localparam int COIN_COUNT = 6;

    typedef logic [MV_W-1:0]  mv_tab_t  [MAX_POINTS];
    typedef logic [PCT_W-1:0] pct_tab_t [MAX_POINTS];

    // Two alkaline cells in series, falling voltage.
    localparam mv_tab_t ALK_MV = '{
        13'd3200, 13'd3000, 13'd2900, 13'd2600, 13'd2520, 13'd2400, 13'd2280, 13'd1800,
        13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0
    };
    localparam pct_tab_t ALK_PCT = '{
        7'd100, 7'd94, 7'd88, 7'd40, 7'd28, 7'd16, 7'd10, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    // Coin cell, falling voltage.
    localparam mv_tab_t COIN_MV = '{
        13'd2900, 13'd2700, 13'd2600, 13'd2500, 13'd2200, 13'd2000, 13'd0, 13'd0,
        13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0
    };
    localparam pct_tab_t COIN_PCT = '{
        7'd100, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    // Voltage of one breakpoint of the selected table.
    function automatic logic [MV_W-1:0] tbl_mv(input logic [CHEM_W-1:0] chem,
                                               input logic [IDX_W-1:0] idx);
        tbl_mv = (chem == CHEM_COIN) ? COIN_MV[idx] : ALK_MV[idx];
    endfunction

    // Percent of one breakpoint of the selected table.
    function automatic logic [PCT_W-1:0] tbl_pct(input logic [CHEM_W-1:0] chem,
                                                 input logic [IDX_W-1:0] idx);
        tbl_pct = (chem == CHEM_COIN) ? COIN_PCT[idx] : ALK_PCT[idx];
    endfunction

    // Number of points in use, cut to TABLE_POINTS.
    function automatic logic [CNT_W-1:0] tbl_count(input logic [CHEM_W-1:0] chem);
        int n;
        n = (chem == CHEM_COIN) ? COIN_COUNT : ALK_COUNT;
        if (n > TABLE_POINTS)
        begin
            n = TABLE_POINTS;
        end
        tbl_count = CNT_W'(n);
    endfunction

    // Saturate a wide intermediate to the percent range.
    function automatic logic [PCT_W-1:0] clamp_pct(input logic [NUM_W-1:0] v);
        clamp_pct = (v > NUM_W'(PCT_FULL)) ? PCT_FULL : v[PCT_W-1:0];
    endfunction

endpackage

>>> src/bvp_ifs.sv
// Handshake channels of the battery voltage to percent unit: voltage samples in,
// percent results out, and the chemistry configuration write. Depends on bvp_pkg.
`timescale 1ns / 1ps

interface bvp_in_if import bvp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] millivolts;

    modport source (output valid, output millivolts, input ready);
    modport sink   (input valid, input millivolts, output ready);
endinterface

interface bvp_out_if import bvp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] percent;

    modport source (output valid, output percent, input ready);
    modport sink   (input valid, input percent, output ready);
endinterface

interface bvp_cfg_if import bvp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHEM_W-1:0] chemistry;

    modport source (output valid, output chemistry, input ready);
    modport sink   (input valid, input chemistry, output ready);
endinterface

>>> src/battery_voltage_to_percent_unit.sv
// Top level of the battery voltage to percent unit: sequencer, shared subtract unit,
// breakpoint search, small multipliers and restoring divider. Depends on bvp_pkg, bvp_ifs.
`timescale 1ns / 1ps

// Converts one battery voltage word (millivolts) into a state-of-charge percent word.
// The chemistry register picks lithium-ion (clamped linear law), two-cell alkaline or
// coin cell (breakpoint tables with truncating interpolation); code 3 acts as
// lithium-ion. One word is in flight at a time and sample.ready is low while it is
// worked on. A clamped lithium-ion voltage goes straight to the output state and any
// other lithium-ion voltage passes the finishing state first (the divide by 15 is a
// constant reciprocal multiply). In table mode the search visits one point a cycle; it
// stops at the first point for a voltage above it and at the last point for one below
// every point. A voltage inside a segment then passes the multiply state, a bit-serial
// divide on the same subtract unit, the finishing state and the output state that
// loads the result. sample.ready rises at the edge that loads the result register, so
// the next word can be accepted while a finished word still waits to be taken; a
// second finished word waits in the sequencer with sample.ready low until the first
// one is taken.
// Configuration writes are taken at any time and should be made while idle.
module battery_voltage_to_percent_unit
    import bvp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bvp_in_if.sink           sample,
    bvp_out_if.source        result,
    bvp_cfg_if.sink          cfg
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]           state_reg,     state_next;
    logic [CHEM_W-1:0]    chem_reg,      chem_next;
    logic [CHEM_W-1:0]    item_chem_reg, item_chem_next;
    logic [MV_W-1:0]      mv_reg,        mv_next;
    logic                 lin_reg,       lin_next;
    logic [IDX_W-1:0]     idx_reg,       idx_next;
    logic [NUM_W-1:0]     num_reg,       num_next;
    logic [MV_W-1:0]      rem_reg,       rem_next;
    logic [MV_W-1:0]      den_reg,       den_next;
    logic [PCT_W-1:0]     drop_reg,      drop_next;
    logic [MV_W-1:0]      dist_reg,      dist_next;
    logic [PCT_W-1:0]     base_reg,      base_next;
    logic [DIV_CNT_W-1:0] cnt_reg,       cnt_next;
    logic [PCT_W-1:0]     res_reg,       res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]     out_pct_reg,   out_pct_next;

    // Shared subtract unit: borrow out means a < b.
    logic [MV_W:0]        alu_a;
    logic [MV_W:0]        alu_b;
    logic [MV_W+1:0]      alu_diff;
    logic                 alu_borrow;

    logic [CNT_W-1:0]     n_pts;
    logic [IDX_W-1:0]     idx_prev;
    logic [MV_W-1:0]      hi_mv;
    logic [MV_W-1:0]      lo_mv;
    logic [MV_W-1:0]      seg_run;
    logic [MV_W:0]        trial;
    logic [LI_PROD_W-1:0] lin_prod;
    logic                 in_fire;

    assign in_fire       = sample.valid && sample.ready;
    assign sample.ready  = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.percent = out_pct_reg;

    // Table lookups for the point under test and the one before it.
    assign n_pts    = tbl_count(item_chem_reg);
    assign idx_prev = idx_reg - IDX_W'(1);
    assign hi_mv    = tbl_mv(item_chem_reg, idx_prev);
    assign lo_mv    = tbl_mv(item_chem_reg, idx_reg);
    assign seg_run  = hi_mv - lo_mv;
    assign trial    = {rem_reg, num_reg[NUM_W-1]};

    // Lithium-ion quotient mv * 2 / 15 by a constant reciprocal multiply.
    assign lin_prod = LI_PROD_W'(mv_reg) * LI_PROD_W'(LI_RECIP);

    // Operand selection for the shared subtract unit.
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            ST_SEARCH:
            begin
                if (idx_reg == '0)
                begin
                    alu_a = {1'b0, lo_mv};
                    alu_b = {1'b0, mv_reg};
                end
                else
                begin
                    alu_a = {1'b0, mv_reg};
                    alu_b = {1'b0, lo_mv};
                end
            end
            ST_DIV:
            begin
                alu_a = trial;
                alu_b = {1'b0, den_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[MV_W+1];

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        chem_next      = chem_reg;
        item_chem_next = item_chem_reg;
        mv_next        = mv_reg;
        lin_next       = lin_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        drop_next      = drop_reg;
        dist_next      = dist_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_pct_next   = out_pct_reg;

        if (cfg.valid)
        begin
            chem_next = cfg.chemistry;
        end

        // The output register frees up when its word is taken.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mv_next        = sample.millivolts;
                    item_chem_next = chem_reg;
                    idx_next       = '0;
                    rem_next       = '0;
                    cnt_next       = '0;
                    if (chem_reg == CHEM_ALK || chem_reg == CHEM_COIN)
                    begin
                        lin_next = 1'b0;
                        if (tbl_count(chem_reg) == '0)
                        begin
                            res_next   = PCT_EMPTY;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        lin_next = 1'b1;
                        if (sample.millivolts >= LI_FULL_MV)
                        begin
                            res_next   = PCT_FULL;
                            state_next = ST_OUT;
                        end
                        else if (sample.millivolts <= LI_EMPTY_MV)
                        begin
                            res_next   = PCT_EMPTY;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                if (idx_reg == '0)
                begin
                    // Above the first point, or a one-point table.
                    if (alu_borrow || n_pts == CNT_W'(1))
                    begin
                        res_next   = tbl_pct(item_chem_reg, idx_reg);
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else if (!alu_borrow)
                begin
                    // Segment found: set up the interpolation.
                    base_next = tbl_pct(item_chem_reg, idx_prev);
                    drop_next = tbl_pct(item_chem_reg, idx_prev)
                              - tbl_pct(item_chem_reg, idx_reg);
                    dist_next = hi_mv - mv_reg;
                    den_next  = seg_run;
                    if (seg_run == '0)
                    begin
                        res_next   = tbl_pct(item_chem_reg, idx_prev);
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else if (CNT_W'(idx_reg) == n_pts - CNT_W'(1))
                begin
                    // Below every point.
                    res_next   = tbl_pct(item_chem_reg, idx_reg);
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_MUL:
            begin
                num_next   = drop_reg * dist_reg;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // One restoring step: quotient bits shift into the dividend register.
                rem_next = alu_borrow ? trial[MV_W-1:0] : alu_diff[MV_W-1:0];
                num_next = {num_reg[NUM_W-2:0], !alu_borrow};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (lin_reg)
                begin
                    res_next = clamp_pct(NUM_W'(lin_prod[LI_PROD_W-1:LI_SHIFT]) - LI_OFFSET);
                end
                else
                begin
                    res_next = clamp_pct(NUM_W'(base_reg) - num_reg);
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pct_next   = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chem_reg      <= CHEM_LIION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chem_reg      <= chem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        item_chem_reg <= item_chem_next;
        mv_reg        <= mv_next;
        lin_reg       <= lin_next;
        idx_reg       <= idx_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        drop_reg      <= drop_next;
        dist_reg      <= dist_next;
        base_reg      <= base_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        out_pct_reg   <= out_pct_next;
    end

    // A result word never exceeds full charge.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.percent <= PCT_FULL)
        else $error("percent above full charge");

    // The divider never runs with a zero divisor.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != '0)
        else $error("divide by zero in divider");

    // No second word is taken in the cycle after one is accepted.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !sample.ready)
        else $error("second word accepted while busy");

    // The breakpoint search stays inside the table in use.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> CNT_W'(idx_reg) < n_pts)
        else $error("breakpoint index beyond table");

endmodule

>>> tb/sv/soc_checker.sv
// Checker for the battery voltage to percent unit: follows the chemistry writes,
// predicts the percent word of every accepted voltage word and compares it with the
// percent words that leave the block. Depends on bvp_pkg and bvp_ifs.
`timescale 1ns / 1ps

module soc_checker
    import bvp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bvp_in_if    sample,
    bvp_out_if   result,
    bvp_cfg_if   cfg,
    output int   fail_count,
    output int   due_count,
    output int   words_checked
);

    // Own copy of the chemistry register and the percent words still owed.
    logic [CHEM_W-1:0] chem_shadow = CHEM_LIION;
    logic [PCT_W-1:0]  percent_due [$];
    logic [PCT_W-1:0]  percent_want;
    int                mismatches = 0;
    int                pending_words = 0;
    int                checked = 0;

    assign fail_count    = mismatches;
    assign due_count     = pending_words;
    assign words_checked = checked;

    // One breakpoint of the alkaline or coin cell discharge curve.
    function automatic void curve_knee(input logic [CHEM_W-1:0] chem, input int idx,
                                       output int knee_mv, output int knee_pct);
        knee_mv  = 0;
        knee_pct = 0;
        if (chem == CHEM_COIN)
        begin
            case (idx)
                0: begin knee_mv = 2900; knee_pct = 100; end
                1: begin knee_mv = 2700; knee_pct = 30;  end
                2: begin knee_mv = 2600; knee_pct = 20;  end
                3: begin knee_mv = 2500; knee_pct = 10;  end
                4: begin knee_mv = 2200; knee_pct = 5;   end
                5: begin knee_mv = 2000; knee_pct = 0;   end
                default: ;
            endcase
        end
        else
        begin
            case (idx)
                0: begin knee_mv = 3200; knee_pct = 100; end
                1: begin knee_mv = 3000; knee_pct = 94;  end
                2: begin knee_mv = 2900; knee_pct = 88;  end
                3: begin knee_mv = 2600; knee_pct = 40;  end
                4: begin knee_mv = 2520; knee_pct = 28;  end
                5: begin knee_mv = 2400; knee_pct = 16;  end
                6: begin knee_mv = 2280; knee_pct = 10;  end
                7: begin knee_mv = 1800; knee_pct = 0;   end
                default: ;
            endcase
        end
    endfunction

    // State of charge for one voltage under the given chemistry.
    function automatic logic [PCT_W-1:0] predict_percent(input logic [CHEM_W-1:0] chem,
                                                         input logic [MV_W-1:0] mv);
        int  volts;
        int  knees;
        int  k;
        int  hi_mv;
        int  hi_pct;
        int  lo_mv;
        int  lo_pct;
        int  pct;
        bit  found;
        volts = int'(mv);
        pct   = 0;
        if (chem == CHEM_ALK || chem == CHEM_COIN)
        begin
            knees = (chem == CHEM_COIN) ? 6 : 8;
            if (knees > TABLE_POINTS)
            begin
                knees = TABLE_POINTS;
            end
            curve_knee(chem, 0, hi_mv, hi_pct);
            if (volts > hi_mv)
            begin
                pct = hi_pct;
            end
            else
            begin
                // Walk down the curve to the first knee at or below the voltage.
                found = 1'b0;
                for (k = 1; k < knees && !found; k++)
                begin
                    curve_knee(chem, k, lo_mv, lo_pct);
                    if (volts >= lo_mv)
                    begin
                        found = 1'b1;
                        if (hi_mv == lo_mv)
                        begin
                            pct = hi_pct;
                        end
                        else
                        begin
                            pct = hi_pct - ((hi_pct - lo_pct) * (hi_mv - volts)) /
                                  (hi_mv - lo_mv);
                        end
                    end
                    else
                    begin
                        hi_mv  = lo_mv;
                        hi_pct = lo_pct;
                    end
                end
                // Below every knee the last percent holds.
                if (!found)
                begin
                    pct = hi_pct;
                end
            end
        end
        else
        begin
            // Lithium-ion, and the unused code, follow the clamped straight line.
            if (volts >= 4200)
            begin
                pct = 100;
            end
            else if (volts <= 3450)
            begin
                pct = 0;
            end
            else
            begin
                pct = volts * 2 / 15 - 459;
            end
        end
        if (pct > 100)
        begin
            pct = 100;
        end
        return pct[PCT_W-1:0];
    endfunction

    // Track configuration, queue predictions and compare the outgoing words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chem_shadow = CHEM_LIION;
            percent_due.delete();
            pending_words = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                chem_shadow = cfg.chemistry;
            end
            if (sample.valid && sample.ready)
            begin
                percent_due.push_back(predict_percent(chem_shadow, sample.millivolts));
                pending_words++;
            end
            if (result.valid && result.ready)
            begin
                if (percent_due.size() == 0)
                begin
                    $error("percent word %0d arrived with no voltage word pending",
                           result.percent);
                    mismatches++;
                end
                else
                begin
                    percent_want = percent_due.pop_front();
                    pending_words--;
                    checked++;
                    if (result.percent !== percent_want)
                    begin
                        $error("percent mismatch: expected %0d, actual %0d",
                               percent_want, result.percent);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_battery_voltage_to_percent_unit.sv
// Testbench top for the battery voltage to percent unit: clock, reset, voltage and
// chemistry stimulus, the percent word receiver and the verdict. Depends on bvp_pkg,
// bvp_ifs, soc_checker and the unit itself.
`timescale 1ns / 1ps

module tb_battery_voltage_to_percent_unit;
    import bvp_pkg::*;

    localparam logic [CHEM_W-1:0] CHEM_SPARE = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 106;
    localparam int MAX_GAP       = 8;
    localparam int LONG_STALL    = 200;
    localparam int DRAIN_TAIL    = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bvp_in_if  sample_ch ();
    bvp_out_if result_ch ();
    bvp_cfg_if cfg_ch ();

    int fail_count;
    int due_count;
    int words_checked;
    int cycle_count = 0;
    int words_sent  = 0;
    int chem_writes = 0;

    // Idle controls of the voltage feeder and the percent receiver, and the long stall request.
    bit feed_idle      = 1'b1;
    bit drain_idle     = 1'b1;
    bit long_stall_req = 1'b0;

    battery_voltage_to_percent_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    soc_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .words_checked (words_checked)
    );

    always #6 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one voltage word after a random gap and hold it until it is taken.
    task automatic send_voltage(input logic [MV_W-1:0] mv);
        int gap;
        gap = feed_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.millivolts <= mv;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        words_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every percent word owed has come out.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (due_count != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    // Write the chemistry register; the block is idle when this is called.
    task automatic write_chemistry(input logic [CHEM_W-1:0] chem);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.chemistry <= chem;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        chem_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Edge voltages of each conversion: clamps, knees and their neighbors.
    task automatic run_directed(input logic [CHEM_W-1:0] chem);
        int pts [$];
        case (chem)
            CHEM_LIION: pts = '{0, 8191, 3450, 3451, 3825, 4199, 4200};
            CHEM_ALK:   pts = '{3201, 3200, 3000, 2950, 2600, 2520, 2280, 1800, 1799};
            CHEM_COIN:  pts = '{2901, 2900, 2650, 2200, 2000, 1999};
            default:    pts = '{0, 8191, 3451};
        endcase
        foreach (pts[k])
        begin
            send_voltage(MV_W'(pts[k]));
        end
    endtask

    // Random voltage, weighted toward the active region of the chemistry.
    function automatic logic [MV_W-1:0] pick_millivolts(input logic [CHEM_W-1:0] chem);
        int knees [$];
        int sel;
        int v;
        knees = '{4200, 3450, 3200, 3000, 2900, 2600, 2520, 2400, 2280, 1800,
                  2700, 2500, 2200, 2000};
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            v = $urandom_range(0, 8191);
        end
        else if (sel <= 2)
        begin
            v = knees[$urandom_range(0, knees.size() - 1)] + int'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            case (chem)
                CHEM_ALK:  v = $urandom_range(1750, 3250);
                CHEM_COIN: v = $urandom_range(1950, 2950);
                default:   v = $urandom_range(3400, 4250);
            endcase
        end
        return MV_W'(v);
    endfunction

    // Percent word receiver: random hold-offs, plus one long stall on request.
    initial
    begin : percent_drain
        int  gap;
        bit  stall_done;
        stall_done      = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall_req && !stall_done)
            begin
                stall_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            gap = drain_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    // Main sequence: reset, directed words per chemistry, then random phases.
    initial
    begin : stimulus
        logic [CHEM_W-1:0] phase_chem [RANDOM_PHASES];
        phase_chem = '{CHEM_COIN, CHEM_LIION, CHEM_ALK, CHEM_SPARE,
                       CHEM_ALK, CHEM_LIION, CHEM_COIN, CHEM_ALK};
        sample_ch.valid      = 1'b0;
        sample_ch.millivolts = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.chemistry     = CHEM_LIION;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset chemistry first, then every other code by a write.
        run_directed(CHEM_LIION);
        wait_drained();
        write_chemistry(CHEM_ALK);
        run_directed(CHEM_ALK);
        wait_drained();
        write_chemistry(CHEM_COIN);
        run_directed(CHEM_COIN);
        wait_drained();
        write_chemistry(CHEM_SPARE);
        run_directed(CHEM_SPARE);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            write_chemistry(phase_chem[p]);
            feed_idle  = (p != 2 && p != 3);
            drain_idle = (p != 2);
            if (p == 3)
            begin
                // Back-to-back offers against a stalled receiver fill the block.
                long_stall_req = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 5 && n == PHASE_WORDS / 2)
                begin
                    wait_drained();
                end
                send_voltage(pick_millivolts(phase_chem[p]));
            end
        end

        wait_drained();
        $display("Sent %0d voltage words, checked %0d percent words, %0d chemistry writes.",
                 words_sent, words_checked, chem_writes);
        $display("Covered codes 0 to 3, clamps and knees, a long output stall and a pause.");
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
